// ===== sv/tcw_pkg.sv =====
// Shared types, constants and screen geometry for the text console writer.
// No dependencies; tcw_addr, tcw_ctrl and text_console_writer refer to it by scoped names.
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry.
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    // Character codes with a special meaning.
    localparam logic [7:0]  CH_NEWLINE   = 8'd10;
    localparam logic [7:0]  CH_BACKSPACE = 8'd8;
    localparam logic [7:0]  CH_TAB       = 8'd9;
    localparam logic [7:0]  CH_SPACE     = 8'd32;
    localparam logic [15:0] BLANK_RESET  = 16'h0720;

    // Item operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration port.
    localparam int         PADDR_W        = 3;
    localparam int         PDATA_W        = 32;
    localparam logic       REG_TEXT_COLOR = 1'b0;
    localparam logic       REG_TAB_LEN    = 1'b1;
    localparam logic [7:0] TEXT_COLOR_RST = 8'd7;
    localparam logic [3:0] TAB_LEN_RST    = 4'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLACE,
        ST_BLANK,
        ST_BACK,
        ST_READ,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MD_PLAIN,
        MD_NEWLINE,
        MD_TAB,
        MD_BACKSPACE
    } t_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_item;

    typedef struct packed {
        logic [7:0] text_color;
        logic [3:0] tab_len;
    } t_cfg;

    // One screen access, in logical (cursor) coordinates.
    typedef struct packed {
        logic          we;
        logic [15:0]   wdata;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
        logic [RW-1:0] top;
    } t_mem_req;

    typedef struct packed {
        logic        valid;
        logic [15:0] cell_data;
        logic [10:0] pos;
    } t_result;

endpackage

// ===== sv/tcw_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tcw_addr.sv =====
// Shared address unit: maps a logical row and column onto the circular row
// buffer of the screen memory. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_addr (
    input  tcw_pkg::t_mem_req             i_req,
    output logic [tcw_pkg::AW-1:0]        o_addr
);

    localparam logic [tcw_pkg::RW:0]   ROWS_X = (tcw_pkg::RW + 1)'(tcw_pkg::ROWS);
    localparam logic [tcw_pkg::AW-1:0] COLS_A = tcw_pkg::AW'(tcw_pkg::COLS);

    logic [tcw_pkg::RW:0]   w_sum;
    logic [tcw_pkg::RW-1:0] w_phys;

    // The top-of-screen pointer rotates on a scroll, so the physical row is
    // the logical row plus the pointer, modulo the row count.
    always_comb begin
        w_sum = {1'b0, i_req.row} + {1'b0, i_req.top};
        if (w_sum >= ROWS_X) begin
            w_phys = w_sum[tcw_pkg::RW-1:0] - ROWS_X[tcw_pkg::RW-1:0];
        end else begin
            w_phys = w_sum[tcw_pkg::RW-1:0];
        end
        o_addr = tcw_pkg::AW'(tcw_pkg::AW'(w_phys) * COLS_A + tcw_pkg::AW'(i_req.col));
    end

endmodule

// ===== sv/tcw_ctrl.sv =====
// Sequencer of the console: cursor, scroll pointer, clearing pass and the
// per-item step loop. Depends on tcw_pkg; drives tcw_addr and tcw_ram.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  tcw_pkg::t_item       i_item,
    input  tcw_pkg::t_cfg        i_cfg,
    input  logic [15:0]          i_rd_data,
    input  logic                 i_out_free,
    output logic                 o_ready,
    output tcw_pkg::t_mem_req    o_mem,
    output tcw_pkg::t_result     o_res
);

    localparam logic [tcw_pkg::CW-1:0] COL_LAST = tcw_pkg::CW'(tcw_pkg::COLS - 1);
    localparam logic [tcw_pkg::RW-1:0] ROW_LAST = tcw_pkg::RW'(tcw_pkg::ROWS - 1);
    localparam logic [tcw_pkg::AW-1:0] COLS_A   = tcw_pkg::AW'(tcw_pkg::COLS);
    localparam logic [5:0]             ROWS_6   = 6'(tcw_pkg::ROWS);
    localparam logic [7:0]             COLS_8   = 8'(tcw_pkg::COLS);

    tcw_pkg::t_state        r_state, n_state;
    tcw_pkg::t_mode         r_mode, n_mode;
    logic [tcw_pkg::RW-1:0] r_row, n_row;
    logic [tcw_pkg::CW-1:0] r_col, n_col;
    logic [tcw_pkg::RW-1:0] r_top, n_top;
    logic [tcw_pkg::RW-1:0] r_wrow, n_wrow;
    logic [tcw_pkg::CW-1:0] r_wcol, n_wcol;
    logic [7:0]             r_char, n_char;
    logic [3:0]             r_cnt, n_cnt;
    logic                   r_more, n_more;
    logic                   r_rd_ok, n_rd_ok;
    logic [15:0]            r_cell, n_cell;

    logic                   w_col_end;
    logic                   w_row_end;
    logic                   w_more;
    logic                   w_wcol_end;
    logic [tcw_pkg::RW-1:0] w_back_row;
    logic [tcw_pkg::CW-1:0] w_back_col;
    logic [tcw_pkg::AW-1:0] w_pos;

    always_comb begin
        w_col_end  = (r_col == COL_LAST);
        w_row_end  = (r_row == ROW_LAST);
        w_wcol_end = (r_wcol == COL_LAST);
        unique case (r_mode)
            tcw_pkg::MD_NEWLINE: w_more = !w_col_end;
            tcw_pkg::MD_TAB:     w_more = (r_cnt != 4'd1);
            default:             w_more = 1'b0;
        endcase
        // One step back; column zero goes to the end of the row above,
        // and the top row wraps to the bottom row.
        if (r_col == '0) begin
            w_back_col = COL_LAST;
            w_back_row = (r_row == '0) ? ROW_LAST : r_row - 1'b1;
        end else begin
            w_back_col = r_col - 1'b1;
            w_back_row = r_row;
        end
        w_pos = tcw_pkg::AW'(tcw_pkg::AW'(r_row) * COLS_A + tcw_pkg::AW'(r_col));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                if (r_wrow == ROW_LAST && w_wcol_end) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_item.op == tcw_pkg::OP_READ) begin
                        n_state = tcw_pkg::ST_READ;
                    end else if (i_item.char_code == tcw_pkg::CH_TAB
                                 && i_cfg.tab_len == 4'd0) begin
                        n_state = tcw_pkg::ST_DONE;
                    end else begin
                        n_state = tcw_pkg::ST_PLACE;
                    end
                end
            end
            tcw_pkg::ST_PLACE: begin
                if (w_col_end && w_row_end) begin
                    n_state = tcw_pkg::ST_BLANK;
                end else if (w_more) begin
                    n_state = tcw_pkg::ST_PLACE;
                end else if (r_mode == tcw_pkg::MD_BACKSPACE) begin
                    n_state = tcw_pkg::ST_BACK;
                end else begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_BLANK: begin
                if (w_wcol_end) begin
                    if (r_more) begin
                        n_state = tcw_pkg::ST_PLACE;
                    end else if (r_mode == tcw_pkg::MD_BACKSPACE) begin
                        n_state = tcw_pkg::ST_BACK;
                    end else begin
                        n_state = tcw_pkg::ST_DONE;
                    end
                end
            end
            tcw_pkg::ST_BACK: n_state = tcw_pkg::ST_DONE;
            tcw_pkg::ST_READ: n_state = tcw_pkg::ST_DONE;
            tcw_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready   = (r_state == tcw_pkg::ST_IDLE);
        o_mem.we    = 1'b0;
        o_mem.wdata = {i_cfg.text_color, r_char};
        o_mem.row   = r_row;
        o_mem.col   = r_col;
        o_mem.top   = r_top;
        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = tcw_pkg::BLANK_RESET;
                o_mem.row   = r_wrow;
                o_mem.col   = r_wcol;
            end
            tcw_pkg::ST_IDLE: begin
                o_mem.row = tcw_pkg::RW'(i_item.read_row);
                o_mem.col = tcw_pkg::CW'(i_item.read_col);
            end
            tcw_pkg::ST_PLACE: o_mem.we = 1'b1;
            tcw_pkg::ST_BLANK: begin
                o_mem.we    = 1'b1;
                o_mem.wdata = {i_cfg.text_color, tcw_pkg::CH_SPACE};
                o_mem.row   = ROW_LAST;
                o_mem.col   = r_wcol;
            end
            default: o_mem.we = 1'b0;
        endcase
        o_res.valid     = (r_state == tcw_pkg::ST_DONE);
        o_res.cell_data = r_cell;
        o_res.pos       = 11'(w_pos);
    end

    // Datapath next values.
    always_comb begin
        n_mode  = r_mode;
        n_row   = r_row;
        n_col   = r_col;
        n_top   = r_top;
        n_wrow  = r_wrow;
        n_wcol  = r_wcol;
        n_char  = r_char;
        n_cnt   = r_cnt;
        n_more  = r_more;
        n_rd_ok = r_rd_ok;
        n_cell  = r_cell;
        unique case (r_state)
            tcw_pkg::ST_CLEAR: begin
                if (w_wcol_end) begin
                    n_wcol = '0;
                    n_wrow = r_wrow + 1'b1;
                end else begin
                    n_wcol = r_wcol + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_cell  = '0;
                    n_rd_ok = ({1'b0, i_item.read_row} < ROWS_6)
                              && ({1'b0, i_item.read_col} < COLS_8);
                    n_char  = tcw_pkg::CH_SPACE;
                    if (i_item.op == tcw_pkg::OP_WRITE) begin
                        if (i_item.char_code == tcw_pkg::CH_NEWLINE) begin
                            n_mode = tcw_pkg::MD_NEWLINE;
                        end else if (i_item.char_code == tcw_pkg::CH_TAB) begin
                            n_mode = tcw_pkg::MD_TAB;
                            n_cnt  = i_cfg.tab_len;
                        end else if (i_item.char_code == tcw_pkg::CH_BACKSPACE) begin
                            n_mode = tcw_pkg::MD_BACKSPACE;
                            n_row  = w_back_row;
                            n_col  = w_back_col;
                        end else begin
                            n_mode = tcw_pkg::MD_PLAIN;
                            n_char = i_item.char_code;
                        end
                    end
                end
            end
            tcw_pkg::ST_PLACE: begin
                n_more = w_more;
                n_cnt  = r_cnt - 1'b1;
                if (w_col_end) begin
                    n_col = '0;
                    if (w_row_end) begin
                        // Scroll: the oldest row becomes the new bottom row.
                        n_top  = (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
                        n_wcol = '0;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            tcw_pkg::ST_BLANK: n_wcol = r_wcol + 1'b1;
            tcw_pkg::ST_BACK: begin
                n_row = w_back_row;
                n_col = w_back_col;
            end
            tcw_pkg::ST_READ: n_cell = r_rd_ok ? i_rd_data : 16'd0;
            default: n_cell = r_cell;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_CLEAR;
            r_mode  <= tcw_pkg::MD_PLAIN;
            r_row   <= '0;
            r_col   <= '0;
            r_top   <= '0;
            r_wrow  <= '0;
            r_wcol  <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_row   <= n_row;
            r_col   <= n_col;
            r_top   <= n_top;
            r_wrow  <= n_wrow;
            r_wcol  <= n_wcol;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_cnt   <= n_cnt;
        r_more  <= n_more;
        r_rd_ok <= n_rd_ok;
        r_cell  <= n_cell;
    end

endmodule

// ===== sv/text_console_writer.sv =====
// Text console writer: an 80x25 text screen of 16-bit cells with a cursor.
// Each word yields one result word: a printable byte or a backspace writes one cell, a read reads one,
// and a newline or a tab writes one cell per step; a scroll also blanks the new bottom row.
// Throughput: one word at a time; the sequencer returns to idle as its result is registered, and
// a held result stalls the input.
// Reset: cursor home, registers to defaults, then a pass that blanks the screen.
`timescale 1ns / 1ps

module text_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input words.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [7:0]                    i_char_code,
    input  logic [4:0]                    i_read_row,
    input  logic [6:0]                    i_read_col,
    // Result words.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [15:0]                   o_cell_data,
    output logic [10:0]                   o_cursor_pos,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [7:0]  r_text_color;
    logic [3:0]  r_tab_len;
    logic        r_out_valid;
    logic [15:0] r_out_cell;
    logic [10:0] r_out_pos;

    tcw_pkg::t_item          w_item;
    tcw_pkg::t_cfg           w_cfg;
    tcw_pkg::t_mem_req       w_mem;
    tcw_pkg::t_result        w_res;
    logic [tcw_pkg::AW-1:0]  w_addr;
    logic [15:0]             w_rd_data;
    logic                    w_out_free;
    logic                    w_cfg_wr;

    assign w_item = '{op: i_op, char_code: i_char_code,
                      read_row: i_read_row, read_col: i_read_col};
    assign w_cfg  = '{text_color: r_text_color, tab_len: r_tab_len};

    // Configuration registers. Registers are decoded on the word address bit
    // alone; the user must make writes only while it is idle, as the block does not enforce it.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tcw_pkg::TEXT_COLOR_RST;
            r_tab_len    <= tcw_pkg::TAB_LEN_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                tcw_pkg::REG_TEXT_COLOR: r_text_color <= pwdata[7:0];
                tcw_pkg::REG_TAB_LEN:    r_tab_len    <= pwdata[3:0];
                default:                 r_text_color <= r_text_color;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tcw_pkg::REG_TEXT_COLOR: prdata = {24'd0, r_text_color};
            tcw_pkg::REG_TAB_LEN:    prdata = {28'd0, r_tab_len};
            default:                 prdata = '0;
        endcase
    end

    // The sequencer steps through every cell an item touches.
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (w_item),
        .i_cfg      (w_cfg),
        .i_rd_data  (w_rd_data),
        .i_out_free (w_out_free),
        .o_ready    (o_ready),
        .o_mem      (w_mem),
        .o_res      (w_res)
    );

    // Every screen access goes through the one address unit.
    tcw_addr u_addr (
        .i_req  (w_mem),
        .o_addr (w_addr)
    );

    // Screen store, one cell per entry, organized as a circular row buffer.
    tcw_ram #(
        .WIDTH (16),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_addr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rd_data)
    );

    // Output register: a finished word waits here so that the sequencer can
    // return to idle and take the next input word.
    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_out_free) begin
            r_out_cell <= w_res.cell_data;
            r_out_pos  <= w_res.pos;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_data  = r_out_cell;
    assign o_cursor_pos = r_out_pos;

endmodule
